[src/twcs_pkg.sv]
// Shared types, constants and helper functions for the textured wall column shader.
// No dependencies; every other file refers to this package by scoped names.
package twcs_pkg;

    // Texture and screen geometry
    localparam int TEX_SIZE      = 256;
    localparam int TEX_BITS      = 8;
    localparam int TEX_DEPTH     = 65536;
    localparam int SCREEN_HEIGHT = 1024;

    // Field widths
    localparam int ADDR_W  = 16;
    localparam int WORD_W  = 32;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 10;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 16;
    localparam int RGB_W   = 24;
    localparam int RGBA_W  = 32;

    // Span arithmetic: span = (scale * TEX_SIZE) >> SCALE_SHIFT
    localparam int SCALE_SHIFT = 7;
    localparam int PROD_W      = SCALE_W + TEX_BITS + 1;
    localparam int SPAN_W      = PROD_W - SCALE_SHIFT;
    localparam int POS_W       = SPAN_W + 2;
    localparam int OFF_W       = SPAN_W;
    localparam int NUM_W       = OFF_W + SCALE_SHIFT;
    localparam int LIM_W       = SCALE_W + TEX_BITS + 1;
    localparam int REM_W       = SCALE_W + 1;

    // Texture row divider: quotient bits per stage and stage count
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = TEX_BITS / STEPS_PER_STAGE;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int CFG_IDX_W = PADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SHADE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REGION_CEILING = 2'd0,
        REGION_WALL    = 2'd1,
        REGION_FLOOR   = 2'd2
    } t_region;

    // One item as it moves down the pipeline
    typedef struct packed {
        t_cmd                cmd;
        logic [ADDR_W-1:0]   index;
        logic [WORD_W-1:0]   word;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        t_region             region;
        logic [TEX_BITS-1:0] tcol;
        logic [SCALE_W-1:0]  den;
        logic [REM_W-1:0]    rem;
        logic [TEX_BITS-1:0] num_lo;
        logic [TEX_BITS-1:0] quo;
        logic                clamp;
    } t_item;

    // Memory words are little endian; the pixel wants red in the top byte
    function automatic logic [RGBA_W-1:0] byte_reverse(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [RGBA_W-1:0] opaque(input logic [RGB_W-1:0] rgb);
        return {rgb, ALPHA_OPAQUE};
    endfunction

endpackage

[src/textured_wall_column_shader_unit.sv]
// Register stages from input transfer to result: span 2, divider 4, texture
// store 1, output 1. Throughput: one item per cycle while the result side takes
// results, set by the single-port texture store that each item visits once;
// load items take a slot, give no result. Reset clears all valid bits and both
// color registers; the texture store is left as it is and needs no clearing pass.
module textured_wall_column_shader_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [twcs_pkg::ADDR_W-1:0]    i_texel_index,
    input  logic [twcs_pkg::WORD_W-1:0]    i_texel_word,
    input  logic [twcs_pkg::COL_W-1:0]     i_screen_column,
    input  logic [twcs_pkg::ROW_W-1:0]     i_screen_row,
    input  logic [twcs_pkg::SCALE_W-1:0]   i_wall_scale,
    input  logic [twcs_pkg::FRAC_W-1:0]    i_tex_x_frac,
    // Result output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [twcs_pkg::COL_W-1:0]     o_pixel_x,
    output logic [twcs_pkg::ROW_W-1:0]     o_pixel_y,
    output logic [twcs_pkg::RGBA_W-1:0]    o_pixel_rgba,
    output logic [1:0]                     o_region,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [twcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [twcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [twcs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int NS = twcs_pkg::DIV_STAGES;

    logic [twcs_pkg::RGB_W-1:0]      r_ceiling_rgb;
    logic [twcs_pkg::RGB_W-1:0]      r_floor_rgb;
    logic                            cfg_write;
    logic [twcs_pkg::CFG_IDX_W-1:0]  cfg_idx;

    logic                            d_valid [NS+1];
    logic                            d_ready [NS+1];
    twcs_pkg::t_item                 d_item  [NS+1];
    twcs_pkg::t_item                 dq;

    logic                            en_m;
    logic                            en_o;
    logic [twcs_pkg::TEX_BITS-1:0]   trow;
    logic [twcs_pkg::ADDR_W-1:0]     tex_addr;
    logic [twcs_pkg::ADDR_W-1:0]     mem_addr;
    logic                            mem_en;
    logic                            mem_we;
    logic [twcs_pkg::WORD_W-1:0]     mem_rdata;

    logic                            r_m_valid;
    logic [twcs_pkg::COL_W-1:0]      r_m_col;
    logic [twcs_pkg::ROW_W-1:0]      r_m_row;
    twcs_pkg::t_region               r_m_region;

    logic                            r_o_valid;
    logic [twcs_pkg::COL_W-1:0]      r_o_col;
    logic [twcs_pkg::ROW_W-1:0]      r_o_row;
    logic [twcs_pkg::RGBA_W-1:0]     r_o_rgba;
    twcs_pkg::t_region               r_o_region;
    logic [twcs_pkg::RGBA_W-1:0]     n_o_rgba;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[twcs_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling_rgb <= '0;
            r_floor_rgb   <= '0;
        end else if (cfg_write) begin
            if (cfg_idx == twcs_pkg::CFG_CEILING) begin
                r_ceiling_rgb <= pwdata[twcs_pkg::RGB_W-1:0];
            end
            if (cfg_idx == twcs_pkg::CFG_FLOOR) begin
                r_floor_rgb <= pwdata[twcs_pkg::RGB_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            twcs_pkg::CFG_CEILING: prdata = twcs_pkg::PDATA_W'(r_ceiling_rgb);
            twcs_pkg::CFG_FLOOR:   prdata = twcs_pkg::PDATA_W'(r_floor_rgb);
            default:               prdata = '0;
        endcase
    end

    // Span and division setup
    twcs_span u_span (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_cmd           (i_cmd),
        .i_texel_index   (i_texel_index),
        .i_texel_word    (i_texel_word),
        .i_screen_column (i_screen_column),
        .i_screen_row    (i_screen_row),
        .i_wall_scale    (i_wall_scale),
        .i_tex_x_frac    (i_tex_x_frac),
        .i_down_ready    (d_ready[0]),
        .o_ready         (o_ready),
        .o_valid         (d_valid[0]),
        .o_item          (d_item[0])
    );

    // Texture row divider chain
    for (genvar g = 0; g < NS; g++) begin : g_div
        twcs_div_stage u_div (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (d_valid[g]),
            .i_item       (d_item[g]),
            .i_down_ready (d_ready[g+1]),
            .o_ready      (d_ready[g]),
            .o_valid      (d_valid[g+1]),
            .o_item       (d_item[g+1])
        );
    end

    assign dq          = d_item[NS];
    assign d_ready[NS] = en_m;

    // Texture store stage: loads write, shades read, both in item order
    assign en_o     = !r_o_valid || i_ready;
    assign en_m     = !r_m_valid || en_o;
    assign trow     = dq.clamp ? twcs_pkg::TEX_BITS'(twcs_pkg::TEX_SIZE - 1) : dq.quo;
    assign tex_addr = twcs_pkg::ADDR_W'(twcs_pkg::ADDR_W'(trow)
                      * twcs_pkg::ADDR_W'(twcs_pkg::TEX_SIZE) + twcs_pkg::ADDR_W'(dq.tcol));
    assign mem_addr = (dq.cmd == twcs_pkg::CMD_LOAD) ? dq.index : tex_addr;
    assign mem_en   = en_m && d_valid[NS];
    assign mem_we   = dq.cmd == twcs_pkg::CMD_LOAD;

    twcs_tex_ram u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (dq.word),
        .o_rdata (mem_rdata)
    );

    // Drop load items here; shades move on with their coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en_m) begin
            r_m_valid <= d_valid[NS] && (dq.cmd == twcs_pkg::CMD_SHADE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_m_col    <= dq.col;
            r_m_row    <= dq.row;
            r_m_region <= dq.region;
        end
    end

    // Pick the pixel color
    always_comb begin
        unique case (r_m_region)
            twcs_pkg::REGION_CEILING: n_o_rgba = twcs_pkg::opaque(r_ceiling_rgb);
            twcs_pkg::REGION_WALL:    n_o_rgba = twcs_pkg::byte_reverse(mem_rdata);
            twcs_pkg::REGION_FLOOR:   n_o_rgba = twcs_pkg::opaque(r_floor_rgb);
            default:                  n_o_rgba = twcs_pkg::opaque(r_floor_rgb);
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_col    <= r_m_col;
            r_o_row    <= r_m_row;
            r_o_rgba   <= n_o_rgba;
            r_o_region <= r_m_region;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pixel_x    = r_o_col;
    assign o_pixel_y    = r_o_row;
    assign o_pixel_rgba = r_o_rgba;
    assign o_region     = r_o_region;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A load item leaving the divider never turns into a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en_m && d_valid[NS] && (dq.cmd == twcs_pkg::CMD_LOAD) |=> !r_m_valid)
        else $error("load item produced a result");

    // An unclamped wall division ends with a remainder below the divisor
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_valid[NS] && (dq.cmd == twcs_pkg::CMD_SHADE)
        && (dq.region == twcs_pkg::REGION_WALL) && !dq.clamp
        |-> (dq.rem < {1'b0, dq.den}))
        else $error("texture row division remainder out of range");

endmodule

[src/twcs_span.sv]
// Front end of the shader pipeline: wall span, region choice, texture column,
// and setup of the texture row division. Two register stages. Uses twcs_pkg.
module twcs_span (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_cmd,
    input  logic [twcs_pkg::ADDR_W-1:0]   i_texel_index,
    input  logic [twcs_pkg::WORD_W-1:0]   i_texel_word,
    input  logic [twcs_pkg::COL_W-1:0]    i_screen_column,
    input  logic [twcs_pkg::ROW_W-1:0]    i_screen_row,
    input  logic [twcs_pkg::SCALE_W-1:0]  i_wall_scale,
    input  logic [twcs_pkg::FRAC_W-1:0]   i_tex_x_frac,
    input  logic                          i_down_ready,
    output logic                          o_ready,
    output logic                          o_valid,
    output twcs_pkg::t_item               o_item
);

    localparam int FPROD_W = twcs_pkg::FRAC_W + twcs_pkg::TEX_BITS + 1;
    localparam int CMP_W   = (twcs_pkg::NUM_W > twcs_pkg::LIM_W) ?
                             twcs_pkg::NUM_W + 1 : twcs_pkg::LIM_W + 1;

    logic                                r_a_valid;
    logic                                r_b_valid;
    twcs_pkg::t_item                     r_a_item;
    twcs_pkg::t_item                     r_b_item;
    logic [twcs_pkg::OFF_W-1:0]          r_a_off;
    twcs_pkg::t_item                     n_a_item;
    twcs_pkg::t_item                     n_b_item;
    logic [twcs_pkg::OFF_W-1:0]          n_a_off;

    logic                                en_a;
    logic                                en_b;
    logic [twcs_pkg::PROD_W-1:0]         prod;
    logic [twcs_pkg::SPAN_W-1:0]         span;
    logic signed [twcs_pkg::POS_W-1:0]   d_start;
    logic signed [twcs_pkg::POS_W-1:0]   d_adj;
    logic signed [twcs_pkg::POS_W-1:0]   wall_start;
    logic [twcs_pkg::SPAN_W:0]           end_sum;
    logic [twcs_pkg::POS_W-1:0]          wall_end;
    logic signed [twcs_pkg::POS_W-1:0]   row_pos;
    logic signed [twcs_pkg::POS_W-1:0]   row_diff;
    logic                                is_ceiling;
    logic                                is_wall;
    logic [FPROD_W-1:0]                  frac_prod;
    logic [twcs_pkg::NUM_W-1:0]          num;
    logic [CMP_W-1:0]                    lim;

    // Stage enables: a stage loads when it is empty or its content moves on
    assign en_b    = !r_b_valid || i_down_ready;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;

    // Span, start and end of the wall; start truncates toward zero
    always_comb begin
        prod       = twcs_pkg::PROD_W'(i_wall_scale) * twcs_pkg::PROD_W'(twcs_pkg::TEX_SIZE);
        span       = prod[twcs_pkg::PROD_W-1:twcs_pkg::SCALE_SHIFT];
        d_start    = $signed(twcs_pkg::POS_W'(twcs_pkg::SCREEN_HEIGHT))
                   - $signed(twcs_pkg::POS_W'(span));
        d_adj      = d_start + $signed({{(twcs_pkg::POS_W-1){1'b0}}, d_start[twcs_pkg::POS_W-1]});
        wall_start = d_adj >>> 1;
        end_sum    = (twcs_pkg::SPAN_W+1)'(twcs_pkg::SCREEN_HEIGHT)
                   + (twcs_pkg::SPAN_W+1)'(span);
        wall_end   = twcs_pkg::POS_W'(end_sum >> 1);
        row_pos    = $signed(twcs_pkg::POS_W'(i_screen_row));
        row_diff   = row_pos - wall_start;
        is_ceiling = row_pos < wall_start;
        is_wall    = !is_ceiling
                   && (twcs_pkg::POS_W'(i_screen_row) < wall_end)
                   && ((twcs_pkg::ROW_W+1)'(i_screen_row)
                       < (twcs_pkg::ROW_W+1)'(twcs_pkg::SCREEN_HEIGHT))
                   && (i_wall_scale != '0);
        frac_prod  = FPROD_W'(i_tex_x_frac) * FPROD_W'(twcs_pkg::TEX_SIZE);
    end

    // Build stage A content
    always_comb begin
        n_a_item        = '0;
        n_a_item.cmd    = twcs_pkg::t_cmd'(i_cmd);
        n_a_item.index  = i_texel_index;
        n_a_item.word   = i_texel_word;
        n_a_item.col    = i_screen_column;
        n_a_item.row    = i_screen_row;
        n_a_item.region = is_ceiling ? twcs_pkg::REGION_CEILING :
                          is_wall    ? twcs_pkg::REGION_WALL : twcs_pkg::REGION_FLOOR;
        n_a_item.tcol   = frac_prod[twcs_pkg::FRAC_W+twcs_pkg::TEX_BITS-1:twcs_pkg::FRAC_W];
        n_a_item.den    = i_wall_scale;
        n_a_off         = row_diff[twcs_pkg::OFF_W-1:0];
    end

    // Stage B: dividend, clamp test and initial partial remainder
    always_comb begin
        num             = {r_a_off, {twcs_pkg::SCALE_SHIFT{1'b0}}};
        lim             = CMP_W'(r_a_item.den) * CMP_W'(twcs_pkg::TEX_SIZE);
        n_b_item        = r_a_item;
        n_b_item.clamp  = CMP_W'(num) >= lim;
        n_b_item.rem    = twcs_pkg::REM_W'(num >> twcs_pkg::TEX_BITS);
        n_b_item.num_lo = num[twcs_pkg::TEX_BITS-1:0];
        n_b_item.quo    = '0;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_item <= n_a_item;
            r_a_off  <= n_a_off;
        end
        if (en_b) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

[src/twcs_div_stage.sv]
// One stage of the texture row divider: restoring division, two quotient bits
// per stage, with the item's payload carried alongside. Uses twcs_pkg.
module twcs_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  twcs_pkg::t_item i_item,
    input  logic            i_down_ready,
    output logic            o_ready,
    output logic            o_valid,
    output twcs_pkg::t_item o_item
);

    logic                            r_valid;
    twcs_pkg::t_item                 r_item;
    twcs_pkg::t_item                 n_item;
    logic [twcs_pkg::REM_W-1:0]      shifted;
    logic                            take;

    assign o_ready = !r_valid || i_down_ready;

    // Shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
        n_item  = i_item;
        shifted = '0;
        take    = 1'b0;
        for (int s = 0; s < twcs_pkg::STEPS_PER_STAGE; s++) begin
            shifted       = {n_item.rem[twcs_pkg::REM_W-2:0],
                             n_item.num_lo[twcs_pkg::TEX_BITS-1]};
            take          = shifted >= {1'b0, n_item.den};
            n_item.rem    = take ? shifted - {1'b0, n_item.den} : shifted;
            n_item.num_lo = {n_item.num_lo[twcs_pkg::TEX_BITS-2:0], 1'b0};
            n_item.quo    = {n_item.quo[twcs_pkg::TEX_BITS-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/twcs_tex_ram.sv]
// Texture store: single-port RAM, one write or one registered read per cycle.
// Contents are not cleared by reset. Uses twcs_pkg.
module twcs_tex_ram (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_we,
    input  logic [twcs_pkg::ADDR_W-1:0]  i_addr,
    input  logic [twcs_pkg::WORD_W-1:0]  i_wdata,
    output logic [twcs_pkg::WORD_W-1:0]  o_rdata
);

    logic [twcs_pkg::WORD_W-1:0] r_mem [twcs_pkg::TEX_DEPTH];
    logic [twcs_pkg::WORD_W-1:0] r_rdata;

    // Hold the read data while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb.sv]
// Self-checking testbench for textured_wall_column_shader_unit: texel loads, pixel
// shading in every region, color registers over APB, and random traffic with stalls.
// Depends on twcs_pkg for field widths, command and region codes and register indexes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [7:0] FULL_ALPHA = 8'hFF;

    typedef struct {
        logic [twcs_pkg::COL_W-1:0]  x;
        logic [twcs_pkg::ROW_W-1:0]  y;
        logic [twcs_pkg::RGBA_W-1:0] rgba;
        twcs_pkg::t_region           region;
    } t_pixel;

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_valid         = 1'b0;
    logic                              o_ready;
    logic                              i_cmd           = 1'b0;
    logic [twcs_pkg::ADDR_W-1:0]       i_texel_index   = '0;
    logic [twcs_pkg::WORD_W-1:0]       i_texel_word    = '0;
    logic [twcs_pkg::COL_W-1:0]        i_screen_column = '0;
    logic [twcs_pkg::ROW_W-1:0]        i_screen_row    = '0;
    logic [twcs_pkg::SCALE_W-1:0]      i_wall_scale    = '0;
    logic [twcs_pkg::FRAC_W-1:0]       i_tex_x_frac    = '0;
    logic                              o_valid;
    logic                              i_ready         = 1'b0;
    logic [twcs_pkg::COL_W-1:0]        o_pixel_x;
    logic [twcs_pkg::ROW_W-1:0]        o_pixel_y;
    logic [twcs_pkg::RGBA_W-1:0]       o_pixel_rgba;
    logic [1:0]                        o_region;
    logic                              psel            = 1'b0;
    logic                              penable         = 1'b0;
    logic                              pwrite          = 1'b0;
    logic [twcs_pkg::PADDR_W-1:0]      paddr           = '0;
    logic [twcs_pkg::PDATA_W-1:0]      pwdata          = '0;
    logic [twcs_pkg::PDATA_W-1:0]      prdata;
    logic                              pready;

    // Shadow of the block's texture and color registers
    logic [twcs_pkg::WORD_W-1:0] texture_image [twcs_pkg::TEX_DEPTH];
    bit                          texel_loaded  [twcs_pkg::TEX_DEPTH];
    logic [twcs_pkg::RGB_W-1:0]  exp_ceiling_rgb = '0;
    logic [twcs_pkg::RGB_W-1:0]  exp_floor_rgb   = '0;

    t_pixel expected_pixels [$];
    int     mismatches    = 0;
    int     items_sent    = 0;
    bit     source_gaps   = 1'b0;
    bit     sink_stalls   = 1'b0;
    int     hold_requests = 0;
    int     hold_served   = 0;
    int     hold_left     = 0;
    int     stuck_cycles  = 0;

    textured_wall_column_shader_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_texel_index   (i_texel_index),
        .i_texel_word    (i_texel_word),
        .i_screen_column (i_screen_column),
        .i_screen_row    (i_screen_row),
        .i_wall_scale    (i_wall_scale),
        .i_tex_x_frac    (i_tex_x_frac),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_rgba    (o_pixel_rgba),
        .o_region        (o_region),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Turn a little-endian texel word into red-first color order
    function automatic logic [twcs_pkg::RGBA_W-1:0] swap_bytes(
            input logic [twcs_pkg::WORD_W-1:0] w);
        logic [twcs_pkg::RGBA_W-1:0] r;
        for (int b = 0; b < 4; b++) r[8*b +: 8] = w[8*(3-b) +: 8];
        return r;
    endfunction

    // Find the region of a screen row and, for wall rows, the texel address
    function automatic twcs_pkg::t_region classify_pixel(
            input logic [twcs_pkg::ROW_W-1:0] row,
            input logic [twcs_pkg::SCALE_W-1:0] scale,
            input logic [twcs_pkg::FRAC_W-1:0] frac,
            output logic [twcs_pkg::ADDR_W-1:0] addr);
        int span, top, bottom, r, trow, tcol;
        span   = (int'(scale) * twcs_pkg::TEX_SIZE) >> 7;
        top    = (twcs_pkg::SCREEN_HEIGHT - span) / 2;
        bottom = (twcs_pkg::SCREEN_HEIGHT + span) / 2;
        r      = int'(row);
        addr   = '0;
        if (r < top) return twcs_pkg::REGION_CEILING;
        if (r < bottom && r < twcs_pkg::SCREEN_HEIGHT && scale != 0) begin
            trow = ((r - top) * 128) / int'(scale);
            if (trow > twcs_pkg::TEX_SIZE - 1) trow = twcs_pkg::TEX_SIZE - 1;
            tcol = (twcs_pkg::TEX_SIZE * int'(frac)) >> 16;
            addr = twcs_pkg::ADDR_W'(trow * twcs_pkg::TEX_SIZE + tcol);
            return twcs_pkg::REGION_WALL;
        end
        return twcs_pkg::REGION_FLOOR;
    endfunction

    // Predict, then offer one item and hold it until the transfer
    task automatic send_item(input twcs_pkg::t_cmd cmd,
            input logic [twcs_pkg::ADDR_W-1:0] index,
            input logic [twcs_pkg::WORD_W-1:0] word,
            input logic [twcs_pkg::COL_W-1:0] col,
            input logic [twcs_pkg::ROW_W-1:0] row,
            input logic [twcs_pkg::SCALE_W-1:0] scale,
            input logic [twcs_pkg::FRAC_W-1:0] frac);
        t_pixel pix;
        logic [twcs_pkg::ADDR_W-1:0] addr;
        if (source_gaps && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        if (cmd == twcs_pkg::CMD_LOAD) begin
            texture_image[index] = word;
            texel_loaded[index]  = 1'b1;
        end else begin
            pix.x      = col;
            pix.y      = row;
            pix.region = classify_pixel(row, scale, frac, addr);
            unique case (pix.region)
                twcs_pkg::REGION_CEILING: pix.rgba = {exp_ceiling_rgb, FULL_ALPHA};
                twcs_pkg::REGION_WALL:    pix.rgba = swap_bytes(texture_image[addr]);
                default:                  pix.rgba = {exp_floor_rgb, FULL_ALPHA};
            endcase
            expected_pixels.push_back(pix);
        end
        items_sent++;
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_texel_index   <= index;
        i_texel_word    <= word;
        i_screen_column <= col;
        i_screen_row    <= row;
        i_wall_scale    <= scale;
        i_tex_x_frac    <= frac;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic load_texel(input logic [twcs_pkg::ADDR_W-1:0] index,
            input logic [twcs_pkg::WORD_W-1:0] word);
        send_item(twcs_pkg::CMD_LOAD, index, word, twcs_pkg::COL_W'($urandom),
                  twcs_pkg::ROW_W'($urandom), twcs_pkg::SCALE_W'($urandom),
                  twcs_pkg::FRAC_W'($urandom));
    endtask

    // Load the texel a wall row needs if it was never written, sometimes rewrite it
    task automatic shade_pixel(input logic [twcs_pkg::COL_W-1:0] col,
            input logic [twcs_pkg::ROW_W-1:0] row,
            input logic [twcs_pkg::SCALE_W-1:0] scale,
            input logic [twcs_pkg::FRAC_W-1:0] frac);
        logic [twcs_pkg::ADDR_W-1:0] addr;
        if (classify_pixel(row, scale, frac, addr) == twcs_pkg::REGION_WALL &&
            (!texel_loaded[addr] || $urandom_range(9) == 0))
            load_texel(addr, twcs_pkg::WORD_W'($urandom));
        send_item(twcs_pkg::CMD_SHADE, twcs_pkg::ADDR_W'($urandom),
                  twcs_pkg::WORD_W'($urandom), col, row, scale, frac);
    endtask

    // Drop valid, wait for every result, then let the pipeline empty
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [twcs_pkg::CFG_IDX_W-1:0] idx,
            input logic [twcs_pkg::RGB_W-1:0] rgb);
        logic [7:0] junk;
        junk    = 8'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, rgb};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == twcs_pkg::CFG_CEILING) exp_ceiling_rgb = rgb;
        else exp_floor_rgb = rgb;
        @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [twcs_pkg::CFG_IDX_W-1:0] idx,
            input logic [twcs_pkg::RGB_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[twcs_pkg::RGB_W-1:0] !== want)
            note_mismatch($sformatf("register %0d readback: expected %06h, got %06h",
                                    idx, want, prdata[twcs_pkg::RGB_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Both colors come up as zero after reset
    task automatic test_reset_colors();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        read_reg(twcs_pkg::CFG_CEILING, '0);
        read_reg(twcs_pkg::CFG_FLOOR, '0);
        shade_pixel(12'd7, 10'd0, 16'd1, 16'h1234);
        shade_pixel(12'd8, 10'd1023, 16'd1, 16'h4321);
        wait_idle();
    endtask

    // Span borders, zero and full scale, texel address corners, load then read
    task automatic test_region_edges();
        write_reg(twcs_pkg::CFG_CEILING, 24'hFFFFFF);
        write_reg(twcs_pkg::CFG_FLOOR, 24'h000000);
        read_reg(twcs_pkg::CFG_CEILING, 24'hFFFFFF);
        read_reg(twcs_pkg::CFG_FLOOR, 24'h000000);
        load_texel(16'h0000, 32'h11223344);
        load_texel(16'hFFFF, 32'hFFFFFFFF);
        load_texel(16'h8000, 32'h00000000);
        // zero scale: no wall rows at all
        shade_pixel(12'd0, 10'd511, 16'd0, 16'h0000);
        shade_pixel(12'd4095, 10'd512, 16'd0, 16'hFFFF);
        shade_pixel(12'd0, 10'd0, 16'd0, 16'h0000);
        shade_pixel(12'd4095, 10'd1023, 16'd0, 16'hFFFF);
        // two-row span in the middle of the screen
        shade_pixel(12'd1, 10'd510, 16'd1, 16'h0000);
        shade_pixel(12'd2, 10'd511, 16'd1, 16'h0000);
        shade_pixel(12'd3, 10'd512, 16'd1, 16'h0000);
        shade_pixel(12'd4, 10'd513, 16'd1, 16'h0000);
        // last texel row and column, span edges
        shade_pixel(12'd5, 10'd767, 16'd256, 16'hFFFF);
        shade_pixel(12'd6, 10'd768, 16'd256, 16'hFFFF);
        shade_pixel(12'd7, 10'd255, 16'd256, 16'hFFFF);
        shade_pixel(12'd8, 10'd256, 16'd256, 16'hFFFF);
        // span exactly the screen height, and one pair short of it
        shade_pixel(12'd9, 10'd0, 16'd512, 16'h8000);
        shade_pixel(12'd10, 10'd1023, 16'd512, 16'h8000);
        shade_pixel(12'd11, 10'd0, 16'd511, 16'h8000);
        shade_pixel(12'd12, 10'd1023, 16'd511, 16'h8000);
        // largest scale: span far beyond the screen
        shade_pixel(12'd13, 10'd0, 16'hFFFF, 16'hFFFF);
        shade_pixel(12'd14, 10'd1023, 16'hFFFF, 16'hFFFF);
        // rewrite a texel and read it back at once
        load_texel(16'h0000, 32'hA5C30F81);
        shade_pixel(12'd15, 10'd511, 16'd1, 16'h0000);
        wait_idle();
    endtask

    // Hold the result side off so the pipeline fills and input stalls
    task automatic test_backpressure();
        int stop_at;
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        stop_at     = items_sent + 120;
        hold_requests++;
        while (items_sent < stop_at)
            shade_pixel(twcs_pkg::COL_W'($urandom), twcs_pkg::ROW_W'($urandom),
                        twcs_pkg::SCALE_W'($urandom_range(1, 600)),
                        twcs_pkg::FRAC_W'($urandom));
        wait_idle();
    endtask

    // One color setting, then random loads and mostly well-formed shading
    task automatic test_random_phase(input int count,
            input logic [twcs_pkg::RGB_W-1:0] ceil_rgb,
            input logic [twcs_pkg::RGB_W-1:0] flr_rgb, input bit with_idling);
        int stop_at, pick;
        logic [twcs_pkg::SCALE_W-1:0] scale;
        wait_idle();
        write_reg(twcs_pkg::CFG_CEILING, ceil_rgb);
        write_reg(twcs_pkg::CFG_FLOOR, flr_rgb);
        read_reg(twcs_pkg::CFG_FLOOR, flr_rgb);
        source_gaps = with_idling;
        sink_stalls = with_idling;
        stop_at     = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                load_texel(twcs_pkg::ADDR_W'($urandom), twcs_pkg::WORD_W'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 5) scale = '0;
                else if (pick < 10) scale = twcs_pkg::SCALE_W'($urandom_range(65280, 65535));
                else if (pick < 25) scale = twcs_pkg::SCALE_W'($urandom);
                else scale = twcs_pkg::SCALE_W'($urandom_range(1, 600));
                shade_pixel(twcs_pkg::COL_W'($urandom), twcs_pkg::ROW_W'($urandom),
                            scale, twcs_pkg::FRAC_W'($urandom));
            end
        end
    endtask

    // Check each result transfer, then pick the next ready
    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected pixel x=%0d y=%0d rgba=%08h region=%0d",
                                        o_pixel_x, o_pixel_y, o_pixel_rgba, o_region));
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.x || o_pixel_y !== want.y ||
                    o_pixel_rgba !== want.rgba || o_region !== want.region)
                    note_mismatch($sformatf({"pixel mismatch: expected x=%0d y=%0d ",
                        "rgba=%08h region=%0d, got x=%0d y=%0d rgba=%08h region=%0d"},
                        want.x, want.y, want.rgba, want.region,
                        o_pixel_x, o_pixel_y, o_pixel_rgba, o_region));
            end
        end
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(sink_stalls && $urandom_range(99) < 26);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("textured_wall_column_shader_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_colors();
        test_region_edges();
        test_backpressure();
        test_random_phase(350, 24'h000000, 24'hFFFFFF, 1'b0);
        test_random_phase(350, 24'hFFFFFF, 24'h000000, 1'b1);
        test_random_phase(350, twcs_pkg::RGB_W'($urandom), twcs_pkg::RGB_W'($urandom), 1'b1);
        test_random_phase(350, twcs_pkg::RGB_W'($urandom), twcs_pkg::RGB_W'($urandom), 1'b1);
        wait_idle();
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("textured_wall_column_shader_unit test passed");
        else
            $display("textured_wall_column_shader_unit test failed");
        $finish;
    end

endmodule
